### sv/adc_tdc_event_word_parser_unit_assert.svh
// assertion macros for the event word parser
// used by atewp_decode; no other dependencies
`ifndef ADC_TDC_EVENT_WORD_PARSER_UNIT_ASSERT_SVH
`define ADC_TDC_EVENT_WORD_PARSER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ATEWP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("atewp assertion failed");
// next-cycle implication
`define ATEWP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("atewp assertion failed");
`else
`define ATEWP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ATEWP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/atewp_pkg.sv
// shared types and constants for the event word parser
// no dependencies
package atewp_pkg;

  typedef enum logic [1:0] {
    PH_START,
    PH_DATA,
    PH_TRAILER,
    PH_COUNTER
  } phase_t;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_ADC16   = 3'd0;
  localparam kind_t KIND_ADC32   = 3'd1;
  localparam kind_t KIND_TDC16   = 3'd2;
  localparam kind_t KIND_TDC32   = 3'd3;
  localparam kind_t KIND_COUNTER = 3'd4;

  localparam logic [2:0] TYPE_DATA    = 3'd0;
  localparam logic [2:0] TYPE_HEADER  = 3'd2;
  localparam logic [2:0] TYPE_TRAILER = 3'd4;

  localparam logic [1:0] RES_VALUE   = 2'd0;
  localparam logic [1:0] RES_TRAILER = 2'd1;
  localparam logic [1:0] RES_DISCARD = 2'd2;

  localparam logic [1:0] CFG_BOARD_COUNT = 2'd0;
  localparam logic [1:0] CFG_BOARD_KINDS = 2'd1;

  // counter board: seven words, the first one at board start
  localparam logic [5:0] COUNTER_TAIL = 6'd6;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  board_index;
    logic [4:0]  geo_address;
    logic [5:0]  channel_number;
    logic [11:0] sample_value;
    logic [23:0] event_counter;
    logic        header_type_bad;
    logic        trailer_type_bad;
    logic        last_of_event;
  } result_t;

endpackage

### sv/atewp_cfg_regs.sv
// configuration registers: board count (clamped) and per-board kind codes
// depends on atewp_pkg
module atewp_cfg_regs #(
  parameter int MAX_BOARDS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [1:0]                          cfg_index,
  input  logic [23:0]                         cfg_data,
  output logic [3:0]                          active_count,
  output atewp_pkg::kind_t [MAX_BOARDS-1:0]   kinds
);

  logic [3:0] board_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_count <= 4'd1;
      kinds       <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == atewp_pkg::CFG_BOARD_COUNT) begin
        board_count <= cfg_data[3:0];
      end
      if (cfg_index == atewp_pkg::CFG_BOARD_KINDS) begin
        for (int i = 0; i < MAX_BOARDS; i++) begin
          kinds[i] <= cfg_data[3*i +: 3];
        end
      end
    end
  end

  // zero counts as one board, anything above the limit as the limit
  always_comb begin
    if (board_count == 4'd0) begin
      active_count = 4'd1;
    end else if (board_count > 4'(MAX_BOARDS)) begin
      active_count = 4'(MAX_BOARDS);
    end else begin
      active_count = board_count;
    end
  end

endmodule

### sv/atewp_decode.sv
// word register, parse state and single-pass decode of one readout word
// depends on atewp_pkg and adc_tdc_event_word_parser_unit_assert.svh
`include "adc_tdc_event_word_parser_unit_assert.svh"
module atewp_decode #(
  parameter int MAX_BOARDS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [31:0]                        data_word,
  input  logic [3:0]                         active_count,
  input  atewp_pkg::kind_t [MAX_BOARDS-1:0]  kinds,
  input  logic                               slot_free,
  output logic                               res_load,
  output atewp_pkg::result_t                 res
);

  logic                word_valid;
  logic [31:0]         word;
  atewp_pkg::phase_t   phase, phase_next;
  logic [2:0]          cur, cur_next;
  logic [5:0]          words_left, words_left_next;
  logic [4:0]          geo, geo_next;
  logic                hdr_bad, hdr_bad_next;

  logic                advance;
  logic                has_result;
  logic [2:0]          w_type;
  logic [4:0]          w_geo;
  atewp_pkg::kind_t    cur_kind;
  logic                fwd_found, wrap_found, start_found;
  logic [2:0]          fwd_b, wrap_b, start_b;
  atewp_pkg::kind_t    start_kind;
  logic                more_after;
  logic [2:0]          board_after;
  logic [5:0]          words_dec;

  assign advance  = word_valid && slot_free;
  assign in_ready = !word_valid || advance;
  assign res_load = advance && has_result;
  assign w_type   = word[26:24];
  assign w_geo    = word[31:27];
  assign words_dec = (words_left != 6'd0) ? words_left - 6'd1 : 6'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      word_valid <= 1'b1;
    end else if (advance) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= data_word;
    end
  end

  // board search: first usable position from the current one, else from zero
  always_comb begin
    fwd_found  = 1'b0;
    fwd_b      = '0;
    wrap_found = 1'b0;
    wrap_b     = '0;
    more_after = 1'b0;
    cur_kind   = atewp_pkg::KIND_ADC16;
    start_kind = atewp_pkg::KIND_ADC16;
    for (int i = MAX_BOARDS - 1; i >= 0; i--) begin
      if (4'(i) < active_count && kinds[i] <= atewp_pkg::KIND_COUNTER) begin
        wrap_found = 1'b1;
        wrap_b     = 3'(i);
        if (3'(i) >= cur) begin
          fwd_found = 1'b1;
          fwd_b     = 3'(i);
        end
      end
      // an adc/tdc board still to come decides the last trailer of the event
      if (3'(i) > cur && 4'(i) < active_count && kinds[i] <= atewp_pkg::KIND_TDC32) begin
        more_after = 1'b1;
      end
    end
    start_found = fwd_found || wrap_found;
    start_b     = fwd_found ? fwd_b : wrap_b;
    for (int i = 0; i < MAX_BOARDS; i++) begin
      if (cur == 3'(i)) begin
        cur_kind = kinds[i];
      end
      if (start_b == 3'(i)) begin
        start_kind = kinds[i];
      end
    end
  end

  assign board_after = ({1'b0, cur} + 4'd1 >= active_count) ? 3'd0 : cur + 3'd1;

  // next state
  always_comb begin
    phase_next      = phase;
    cur_next        = cur;
    words_left_next = words_left;
    geo_next        = geo;
    hdr_bad_next    = hdr_bad;
    unique case (phase)
      atewp_pkg::PH_START: begin
        if (start_found) begin
          cur_next = start_b;
          if (start_kind == atewp_pkg::KIND_COUNTER) begin
            words_left_next = atewp_pkg::COUNTER_TAIL;
            phase_next      = atewp_pkg::PH_COUNTER;
          end else begin
            hdr_bad_next    = (w_type != atewp_pkg::TYPE_HEADER);
            geo_next        = w_geo;
            words_left_next = word[13:8];
            phase_next      = (word[13:8] != 6'd0) ? atewp_pkg::PH_DATA
                                                   : atewp_pkg::PH_TRAILER;
          end
        end
      end
      atewp_pkg::PH_COUNTER: begin
        words_left_next = words_dec;
        if (words_dec == 6'd0) begin
          cur_next   = board_after;
          phase_next = atewp_pkg::PH_START;
        end
      end
      atewp_pkg::PH_DATA: begin
        words_left_next = words_dec;
        if (words_dec == 6'd0) begin
          phase_next = atewp_pkg::PH_TRAILER;
        end
      end
      atewp_pkg::PH_TRAILER: begin
        cur_next   = board_after;
        phase_next = atewp_pkg::PH_START;
      end
      default: phase_next = atewp_pkg::PH_START;
    endcase
  end

  // result of this word
  always_comb begin
    res             = '0;
    has_result      = 1'b0;
    res.board_index = cur;
    res.geo_address = geo;
    res.header_type_bad = hdr_bad;
    unique case (phase)
      atewp_pkg::PH_DATA: begin
        has_result = 1'b1;
        if (w_type == atewp_pkg::TYPE_DATA && w_geo == geo) begin
          res.result_kind    = atewp_pkg::RES_VALUE;
          res.channel_number = cur_kind[0] ? word[21:16] : {1'b0, word[21:17]};
          // tdc hit without the valid bit reads as zero
          if ((cur_kind == atewp_pkg::KIND_TDC16 || cur_kind == atewp_pkg::KIND_TDC32)
              && !word[14]) begin
            res.sample_value = '0;
          end else begin
            res.sample_value = word[11:0];
          end
        end else begin
          res.result_kind = atewp_pkg::RES_DISCARD;
        end
      end
      atewp_pkg::PH_TRAILER: begin
        has_result           = 1'b1;
        res.result_kind      = atewp_pkg::RES_TRAILER;
        res.event_counter    = word[23:0];
        res.trailer_type_bad = (w_type != atewp_pkg::TYPE_TRAILER);
        res.last_of_event    = !more_after;
      end
      atewp_pkg::PH_START, atewp_pkg::PH_COUNTER: begin
        has_result = 1'b0;
      end
      default: has_result = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= atewp_pkg::PH_START;
      cur        <= '0;
      words_left <= '0;
      geo        <= '0;
      hdr_bad    <= 1'b0;
    end else if (advance) begin
      phase      <= phase_next;
      cur        <= cur_next;
      words_left <= words_left_next;
      geo        <= geo_next;
      hdr_bad    <= hdr_bad_next;
    end
  end

  `ATEWP_ASSERT_IMPL(a_result_phase, clk, rst, res_load,
    phase == atewp_pkg::PH_DATA || phase == atewp_pkg::PH_TRAILER)
  `ATEWP_ASSERT_IMPL(a_data_count, clk, rst, phase == atewp_pkg::PH_DATA,
    words_left != 6'd0)
  `ATEWP_ASSERT_NEXT(a_trailer_ends_board, clk, rst,
    advance && phase == atewp_pkg::PH_TRAILER, phase == atewp_pkg::PH_START)
  `ATEWP_ASSERT_IMPL(a_result_kind_code, clk, rst, res_load,
    res.result_kind != 2'd3)

endmodule

### sv/atewp_out_reg.sv
// result register between the decoder and the output channel
// depends on atewp_pkg
module atewp_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  atewp_pkg::result_t  res,
  output logic                slot_free,
  output logic                out_valid,
  input  logic                out_ready,
  output atewp_pkg::result_t  held
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

### sv/adc_tdc_event_word_parser_unit.sv
// event word parser for a chain of adc/tdc and counter boards
// depends on atewp_pkg, atewp_cfg_regs, atewp_decode, atewp_out_reg
//
// usage:
//   in channel: one 32-bit readout word per handshake (in_valid/in_ready),
//     boards in configured order: header, data words, trailer; counter
//     boards are seven words with no result
//   out channel: at most one result per word (out_valid/out_ready): a channel
//     value or discard report per data word, a trailer report per trailer
//   cfg channel: cfg_index 0 = board count, 1 = board kinds (3 bits each);
//     cfg_ready is always high, write only while the parser is idle
//   path: a word is held in the word register, and its result goes to the
//     result register when that register is empty or being read
//   throughput: one word per cycle while the result register is free; decode
//     is a single pass between the word register and the result register
//   reset: one adc16 board, parser waits for the header of board 0
//   stall: a held result keeps its word register free for one more word;
//     in_ready drops only when both registers are full and out_ready is low
module adc_tdc_event_word_parser_unit #(
  parameter int MAX_BOARDS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [2:0]  board_index,
  output logic [4:0]  geo_address,
  output logic [5:0]  channel_number,
  output logic [11:0] sample_value,
  output logic [23:0] event_counter,
  output logic        header_type_bad,
  output logic        trailer_type_bad,
  output logic        last_of_event,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [3:0]                         active_count;
  atewp_pkg::kind_t [MAX_BOARDS-1:0]  kinds;
  logic                               slot_free;
  logic                               res_load;
  atewp_pkg::result_t                 res;
  atewp_pkg::result_t                 held;

  assign cfg_ready = 1'b1;

  atewp_cfg_regs #(
    .MAX_BOARDS(MAX_BOARDS)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .active_count (active_count),
    .kinds        (kinds)
  );

  atewp_decode #(
    .MAX_BOARDS(MAX_BOARDS)
  ) u_decode (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_word    (data_word),
    .active_count (active_count),
    .kinds        (kinds),
    .slot_free    (slot_free),
    .res_load     (res_load),
    .res          (res)
  );

  atewp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  assign result_kind      = held.result_kind;
  assign board_index      = held.board_index;
  assign geo_address      = held.geo_address;
  assign channel_number   = held.channel_number;
  assign sample_value     = held.sample_value;
  assign event_counter    = held.event_counter;
  assign header_type_bad  = held.header_type_bad;
  assign trailer_type_bad = held.trailer_type_bad;
  assign last_of_event    = held.last_of_event;

endmodule
